### hdl/upst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package upst_pkg;

    // action codes
    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_REMOVE = 3'd1;
    localparam logic [2:0] ACT_FIND   = 3'd2;
    localparam logic [2:0] ACT_SORT   = 3'd3;
    localparam logic [2:0] ACT_SELECT = 3'd4;
    localparam logic [2:0] ACT_READ   = 3'd5;

    // status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_DUP   = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_NONE  = 3'd3;
    localparam logic [2:0] ST_BADIX = 3'd4;

    // stored entry: a in bits 2..0, b in bits 5..3
    localparam int ENTRY_W = 6;
    localparam int VAL_W   = 3;
    localparam int SUM_W   = 4;

    typedef logic [VAL_W-1:0]   t_val;
    typedef logic [ENTRY_W-1:0] t_entry;
    typedef logic [SUM_W-1:0]   t_sum;

    // compare unit results
    typedef struct packed {
        logic pair_eq;
        logic val_hit;
        logic sum_gt;
        t_sum sum;
    } t_alu_res;

endpackage

`default_nettype wire

### hdl/unordered_pair_set_table_top.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | handshake            | ports
// ----------+----------------------+-------------------------------------------------
// command   | start && !busy       | i_action i_pip_a i_pip_b i_match_value i_entry_index
// result    | o_strobe, one cycle  | o_status o_slot o_out_a o_out_b o_entry_count o_last
//
// all work runs on one compare unit and one table ram (one read, one write port) under a sequencer
// insert, remove, find and select scan the whole table; an undefined action answers next cycle
// sort takes one key at a time and shifts each larger entry up by one before placing the key
// select gives one word per cycle at most while the scan runs; the last word comes as busy goes low
// reset is synchronous and clears the state, the fill count and the strobe; results cannot be held off

module unordered_pair_set_table_top #(
    parameter int MAX_ENTRIES = 28
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [2:0] i_action,
    input  wire logic [2:0] i_pip_a,
    input  wire logic [2:0] i_pip_b,
    input  wire logic [2:0] i_match_value,
    input  wire logic [4:0] i_entry_index,
    output logic            o_strobe,
    output logic [2:0]      o_status,
    output logic [4:0]      o_slot,
    output logic [2:0]      o_out_a,
    output logic [2:0]      o_out_b,
    output logic [4:0]      o_entry_count,
    output logic            o_last
);
    import upst_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int XW = (CW > 5) ? CW : 5;
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_END,
        S_RM_RD,
        S_RM_WT,
        S_RM_W2,
        S_RD,
        S_RD_DAT,
        S_SRT_KEY,
        S_SRT_KEYC,
        S_SRT_PRV,
        S_SRT_CMP
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_ptr, n_ptr;
    logic          r_dv, n_dv;
    logic [IW-1:0] r_didx, n_didx;
    logic          r_hit, n_hit;
    logic [IW-1:0] r_hidx, n_hidx;
    t_entry        r_hent, n_hent;
    logic [2:0]    r_act, n_act;
    t_val          r_a, n_a;
    t_val          r_b, n_b;
    t_val          r_mv, n_mv;
    logic [4:0]    r_ix, n_ix;
    logic [CW-1:0] r_j, n_j;
    logic [IW-1:0] r_i, n_i;
    t_entry        r_key, n_key;
    t_sum          r_ks, n_ks;

    logic          r_strobe, n_strobe;
    logic [2:0]    r_status, n_status;
    logic [4:0]    r_slot, n_slot;
    t_val          r_oa, n_oa;
    t_val          r_ob, n_ob;
    logic [4:0]    r_cnt, n_cnt;
    logic          r_last, n_last;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    t_entry        ram_wdata;
    logic [IW-1:0] ram_raddr;
    t_entry        ram_rdata;
    t_alu_res      alu;
    logic          issue;

    // pair table storage
    upst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // shared compare unit, always fed by the ram read word
    upst_alu u_alu (
        .i_entry   (ram_rdata),
        .i_a       (r_a),
        .i_b       (r_b),
        .i_mv      (r_mv),
        .i_key_sum (r_ks),
        .o_res     (alu)
    );

    assign issue = r_ptr < r_fill;

    // sequencer next state
    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_ptr    = r_ptr;
        n_dv     = r_dv;
        n_didx   = r_didx;
        n_hit    = r_hit;
        n_hidx   = r_hidx;
        n_hent   = r_hent;
        n_act    = r_act;
        n_a      = r_a;
        n_b      = r_b;
        n_mv     = r_mv;
        n_ix     = r_ix;
        n_j      = r_j;
        n_i      = r_i;
        n_key    = r_key;
        n_ks     = r_ks;
        n_strobe = 1'b0;
        n_status = ST_OK;
        n_slot   = '0;
        n_oa     = '0;
        n_ob     = '0;
        n_last   = 1'b1;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = r_ptr[IW-1:0];

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_act = i_action;
                    n_a   = i_pip_a;
                    n_b   = i_pip_b;
                    n_mv  = i_match_value;
                    n_ix  = i_entry_index;
                    n_ptr = '0;
                    n_dv  = 1'b0;
                    n_hit = 1'b0;
                    n_j   = CW'(1);
                    case (i_action)
                        ACT_INSERT, ACT_REMOVE, ACT_FIND, ACT_SELECT: n_state = S_SCAN;
                        ACT_SORT: n_state = S_SRT_KEY;
                        ACT_READ: n_state = S_RD;
                        default: begin
                            n_strobe = 1'b1;
                            n_status = ST_BADIX;
                        end
                    endcase
                end
            end

            // one read issued per cycle, compare on the word returned
            S_SCAN: begin
                if (issue) begin
                    n_ptr = r_ptr + CW'(1);
                end
                n_dv   = issue;
                n_didx = r_ptr[IW-1:0];
                if (r_dv) begin
                    if (r_act == ACT_SELECT) begin
                        if (alu.val_hit) begin
                            // previous pending hit is not the last one
                            if (r_hit) begin
                                n_strobe = 1'b1;
                                n_slot   = 5'(r_hidx);
                                n_oa     = r_hent[VAL_W-1:0];
                                n_ob     = r_hent[ENTRY_W-1:VAL_W];
                                n_last   = 1'b0;
                            end
                            n_hit  = 1'b1;
                            n_hidx = r_didx;
                            n_hent = ram_rdata;
                        end
                    end else if (alu.pair_eq) begin
                        n_hit  = 1'b1;
                        n_hidx = r_didx;
                        n_hent = ram_rdata;
                    end
                end
                if (!issue && !r_dv) begin
                    n_state = S_SCAN_END;
                end
            end

            S_SCAN_END: begin
                n_state  = S_IDLE;
                n_strobe = 1'b1;
                case (r_act)
                    ACT_INSERT: begin
                        if (r_hit) begin
                            n_status = ST_DUP;
                            n_slot   = 5'(r_hidx);
                            n_oa     = r_hent[VAL_W-1:0];
                            n_ob     = r_hent[ENTRY_W-1:VAL_W];
                        end else if (r_fill == FULL_CNT) begin
                            n_status = ST_FULL;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = r_fill[IW-1:0];
                            ram_wdata = {r_b, r_a};
                            n_fill    = r_fill + CW'(1);
                            n_slot    = 5'(r_fill);
                            n_oa      = r_a;
                            n_ob      = r_b;
                        end
                    end
                    ACT_REMOVE: begin
                        if (r_hit) begin
                            n_strobe = 1'b0;
                            n_fill   = r_fill - CW'(1);
                            n_state  = S_RM_RD;
                        end else begin
                            n_status = ST_NONE;
                        end
                    end
                    default: begin
                        // find and select: last hit or none
                        if (r_hit) begin
                            n_slot = 5'(r_hidx);
                            n_oa   = r_hent[VAL_W-1:0];
                            n_ob   = r_hent[ENTRY_W-1:VAL_W];
                        end else begin
                            n_status = ST_NONE;
                        end
                    end
                endcase
            end

            // remove: move the last entry into the hole, removed one to the end
            S_RM_RD: begin
                ram_raddr = r_fill[IW-1:0];
                n_state   = S_RM_WT;
            end

            S_RM_WT: begin
                ram_we    = 1'b1;
                ram_waddr = r_hidx;
                ram_wdata = ram_rdata;
                n_state   = S_RM_W2;
            end

            S_RM_W2: begin
                ram_we    = 1'b1;
                ram_waddr = r_fill[IW-1:0];
                ram_wdata = r_hent;
                n_strobe  = 1'b1;
                n_slot    = 5'(r_hidx);
                n_oa      = r_hent[VAL_W-1:0];
                n_ob      = r_hent[ENTRY_W-1:VAL_W];
                n_state   = S_IDLE;
            end

            // read by index
            S_RD: begin
                ram_raddr = IW'(r_ix);
                if (XW'(r_ix) >= XW'(r_fill)) begin
                    n_strobe = 1'b1;
                    n_status = ST_BADIX;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_RD_DAT;
                end
            end

            S_RD_DAT: begin
                n_strobe = 1'b1;
                n_slot   = r_ix;
                n_oa     = ram_rdata[VAL_W-1:0];
                n_ob     = ram_rdata[ENTRY_W-1:VAL_W];
                n_state  = S_IDLE;
            end

            // insertion sort: fetch key j
            S_SRT_KEY: begin
                ram_raddr = r_j[IW-1:0];
                if (r_j >= r_fill) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_SRT_KEYC;
                end
            end

            S_SRT_KEYC: begin
                n_key   = ram_rdata;
                n_ks    = alu.sum;
                n_i     = r_j[IW-1:0];
                n_state = S_SRT_PRV;
            end

            // fetch the entry below the hole, or drop the key at the bottom
            S_SRT_PRV: begin
                ram_raddr = r_i - IW'(1);
                if (r_i == '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_i;
                    ram_wdata = r_key;
                    n_j       = r_j + CW'(1);
                    n_state   = S_SRT_KEY;
                end else begin
                    n_state = S_SRT_CMP;
                end
            end

            // shift up while its sum is larger, else place the key
            S_SRT_CMP: begin
                ram_we    = 1'b1;
                ram_waddr = r_i;
                if (alu.sum_gt) begin
                    ram_wdata = ram_rdata;
                    n_i       = r_i - IW'(1);
                    n_state   = S_SRT_PRV;
                end else begin
                    ram_wdata = r_key;
                    n_j       = r_j + CW'(1);
                    n_state   = S_SRT_KEY;
                end
            end

            default: n_state = S_IDLE;
        endcase

        n_cnt = 5'(n_fill);
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_strobe <= n_strobe;
            r_ptr    <= n_ptr;
            r_dv     <= n_dv;
            r_didx   <= n_didx;
            r_hit    <= n_hit;
            r_hidx   <= n_hidx;
            r_hent   <= n_hent;
            r_act    <= n_act;
            r_a      <= n_a;
            r_b      <= n_b;
            r_mv     <= n_mv;
            r_ix     <= n_ix;
            r_j      <= n_j;
            r_i      <= n_i;
            r_key    <= n_key;
            r_ks     <= n_ks;
            r_status <= n_status;
            r_slot   <= n_slot;
            r_oa     <= n_oa;
            r_ob     <= n_ob;
            r_cnt    <= n_cnt;
            r_last   <= n_last;
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_slot        = r_slot;
    assign o_out_a       = r_oa;
    assign o_out_b       = r_ob;
    assign o_entry_count = r_cnt;
    assign o_last        = r_last;

    // fill count never passes the table size
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_CNT)
        else $error("fill count above table size");

    // fill count moves by at most one per cycle
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == $past(r_fill)) || (r_fill == $past(r_fill) + CW'(1))
        || (r_fill == $past(r_fill) - CW'(1)))
        else $error("fill count jumped");

    // a word that is not the last keeps the block busy
    a_more_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> busy)
        else $error("partial result with block idle");

    // an accepted command either starts work or answers at once
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("command dropped");

endmodule

`default_nettype wire

### hdl/upst_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module upst_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 28,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hdl/upst_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module upst_alu (
    input  wire logic [5:0]          i_entry,
    input  wire logic [2:0]          i_a,
    input  wire logic [2:0]          i_b,
    input  wire logic [2:0]          i_mv,
    input  wire logic [3:0]          i_key_sum,
    output upst_pkg::t_alu_res       o_res
);
    import upst_pkg::*;

    t_val x;
    t_val y;

    assign x = i_entry[VAL_W-1:0];
    assign y = i_entry[ENTRY_W-1:VAL_W];

    // pair match in either order, value match in either half, sum compare
    always_comb begin
        o_res.pair_eq = ((x == i_a) && (y == i_b)) || ((x == i_b) && (y == i_a));
        o_res.val_hit = (x == i_mv) || (y == i_mv);
        o_res.sum     = {1'b0, x} + {1'b0, y};
        o_res.sum_gt  = o_res.sum > i_key_sum;
    end

endmodule

`default_nettype wire

### test/upst_checker.sv
`timescale 1ns / 1ps

// watches the command and result channels, predicts every result word and compares
module upst_checker #(
    parameter int DEPTH = 28
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_busy,
    input  logic [2:0] i_action,
    input  logic [2:0] i_pip_a,
    input  logic [2:0] i_pip_b,
    input  logic [2:0] i_match_value,
    input  logic [4:0] i_entry_index,
    input  logic       i_strobe,
    input  logic [2:0] i_status,
    input  logic [4:0] i_slot,
    input  logic [2:0] i_out_a,
    input  logic [2:0] i_out_b,
    input  logic [4:0] i_entry_count,
    input  logic       i_last,
    output int         o_fail_count,
    output int         o_words_pending
);
    import upst_pkg::*;

    // one result word as the block emits it
    typedef struct packed {
        logic [2:0] status;
        logic [4:0] slot;
        t_val       a;
        t_val       b;
        logic [4:0] count;
        logic       last;
    } t_result_word;

    // shadow copy of the pair table
    t_val tab_a [DEPTH];
    t_val tab_b [DEPTH];
    int   fill;

    t_result_word words_due [$];
    int           mismatches = 0;

    function automatic void push_word(logic [2:0] st, int slot, t_val a, t_val b, logic lst);
        t_result_word w;
        w.status = st;
        w.slot   = slot[4:0];
        w.a      = a;
        w.b      = b;
        w.count  = fill[4:0];
        w.last   = lst;
        words_due.push_back(w);
    endfunction

    // last stored index holding the pair in either order, or -1
    function automatic int last_pair_hit(t_val a, t_val b);
        int hit;
        hit = -1;
        for (int i = 0; i < fill; i++) begin
            if ((tab_a[i] == a && tab_b[i] == b) || (tab_a[i] == b && tab_b[i] == a))
                hit = i;
        end
        return hit;
    endfunction

    function automatic int pair_sum(int i);
        return int'(tab_a[i]) + int'(tab_b[i]);
    endfunction

    // update the shadow table and queue the words one command causes
    function automatic void apply_command(logic [2:0] act, t_val a, t_val b, t_val mv,
                                          logic [4:0] ix);
        int   hit;
        int   pos;
        int   key_sum;
        int   n;
        t_val ea;
        t_val eb;
        hit = last_pair_hit(a, b);
        case (act)
            ACT_INSERT: begin
                if (hit >= 0) begin
                    push_word(ST_DUP, hit, tab_a[hit], tab_b[hit], 1'b1);
                end else if (fill >= DEPTH) begin
                    push_word(ST_FULL, 0, '0, '0, 1'b1);
                end else begin
                    tab_a[fill] = a;
                    tab_b[fill] = b;
                    fill++;
                    push_word(ST_OK, fill - 1, a, b, 1'b1);
                end
            end
            ACT_REMOVE: begin
                if (hit < 0) begin
                    push_word(ST_NONE, 0, '0, '0, 1'b1);
                end else begin
                    // last entry moves into the freed slot
                    ea = tab_a[hit];
                    eb = tab_b[hit];
                    fill--;
                    tab_a[hit]  = tab_a[fill];
                    tab_b[hit]  = tab_b[fill];
                    tab_a[fill] = ea;
                    tab_b[fill] = eb;
                    push_word(ST_OK, hit, ea, eb, 1'b1);
                end
            end
            ACT_FIND: begin
                if (hit < 0)
                    push_word(ST_NONE, 0, '0, '0, 1'b1);
                else
                    push_word(ST_OK, hit, tab_a[hit], tab_b[hit], 1'b1);
            end
            ACT_SORT: begin
                // stable insertion sort on a + b
                for (int j = 1; j < fill; j++) begin
                    ea      = tab_a[j];
                    eb      = tab_b[j];
                    key_sum = int'(ea) + int'(eb);
                    pos     = j;
                    while (pos > 0 && pair_sum(pos - 1) > key_sum) begin
                        tab_a[pos] = tab_a[pos - 1];
                        tab_b[pos] = tab_b[pos - 1];
                        pos--;
                    end
                    tab_a[pos] = ea;
                    tab_b[pos] = eb;
                end
                push_word(ST_OK, 0, '0, '0, 1'b1);
            end
            ACT_SELECT: begin
                hit = -1;
                for (int i = 0; i < fill; i++)
                    if (tab_a[i] == mv || tab_b[i] == mv)
                        hit = i;
                n = 0;
                for (int i = 0; i < fill; i++) begin
                    if (tab_a[i] == mv || tab_b[i] == mv) begin
                        push_word(ST_OK, i, tab_a[i], tab_b[i], i == hit);
                        n++;
                    end
                end
                if (n == 0)
                    push_word(ST_NONE, 0, '0, '0, 1'b1);
            end
            ACT_READ: begin
                if (int'(ix) >= fill || int'(ix) >= DEPTH)
                    push_word(ST_BADIX, 0, '0, '0, 1'b1);
                else
                    push_word(ST_OK, int'(ix), tab_a[ix], tab_b[ix], 1'b1);
            end
            default: begin
                push_word(ST_BADIX, 0, '0, '0, 1'b1);
            end
        endcase
    endfunction

    // result words are checked before a command on the same edge is predicted
    always @(posedge i_clk) begin
        t_result_word got;
        t_result_word want;
        if (!i_rst_n) begin
            fill = 0;
            words_due.delete();
        end else begin
            if (i_strobe) begin
                got = {i_status, i_slot, i_out_a, i_out_b, i_entry_count, i_last};
                if (words_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"unexpected word: status %0d slot %0d a %0d b %0d",
                                  " count %0d last %0d"},
                                 got.status, got.slot, got.a, got.b, got.count, got.last);
                end else begin
                    want = words_due.pop_front();
                    if (got.status !== want.status || got.slot !== want.slot ||
                        got.a !== want.a || got.b !== want.b ||
                        got.count !== want.count || got.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch at %0t: want st %0d sl %0d a %0d b %0d",
                                      " n %0d l %0d, got st %0d sl %0d a %0d b %0d",
                                      " n %0d l %0d"},
                                     $realtime, want.status, want.slot, want.a, want.b,
                                     want.count, want.last, got.status, got.slot, got.a,
                                     got.b, got.count, got.last);
                    end
                end
            end
            if (i_start && !i_busy)
                apply_command(i_action, i_pip_a, i_pip_b, i_match_value, i_entry_index);
        end
        o_words_pending <= words_due.size();
        o_fail_count    <= mismatches;
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import upst_pkg::*;

    localparam int          MAX_ENTRIES  = 28;
    localparam int          ITEMS        = 330;
    localparam int          CYCLE_LIMIT  = 2000000;
    localparam int          DRAIN_CYCLES = 64;
    localparam logic [2:0]  ACT_UNDEF_LO = 3'd6;
    localparam logic [2:0]  ACT_UNDEF_HI = 3'd7;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       start         = 1'b0;
    logic [2:0] i_action      = '0;
    logic [2:0] i_pip_a       = '0;
    logic [2:0] i_pip_b       = '0;
    logic [2:0] i_match_value = '0;
    logic [4:0] i_entry_index = '0;
    logic       busy;
    logic       o_strobe;
    logic [2:0] o_status;
    logic [4:0] o_slot;
    logic [2:0] o_out_a;
    logic [2:0] o_out_b;
    logic [4:0] o_entry_count;
    logic       o_last;

    int fail_count;
    int words_pending;
    int sent      = 0;
    int cycles    = 0;
    bit no_gaps   = 1'b0;

    // every domino pair of 0..6, shuffled per round
    t_val deck_a [MAX_ENTRIES];
    t_val deck_b [MAX_ENTRIES];

    always #4 i_clk = ~i_clk;

    unordered_pair_set_table_top #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(i_action), .i_pip_a(i_pip_a), .i_pip_b(i_pip_b),
        .i_match_value(i_match_value), .i_entry_index(i_entry_index),
        .o_strobe(o_strobe), .o_status(o_status), .o_slot(o_slot),
        .o_out_a(o_out_a), .o_out_b(o_out_b), .o_entry_count(o_entry_count),
        .o_last(o_last)
    );

    upst_checker #(
        .DEPTH(MAX_ENTRIES)
    ) u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_action(i_action), .i_pip_a(i_pip_a), .i_pip_b(i_pip_b),
        .i_match_value(i_match_value), .i_entry_index(i_entry_index),
        .i_strobe(o_strobe), .i_status(o_status), .i_slot(o_slot),
        .i_out_a(o_out_a), .i_out_b(o_out_b), .i_entry_count(o_entry_count),
        .i_last(o_last), .o_fail_count(fail_count), .o_words_pending(words_pending)
    );

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // values 0..6 mostly, seven now and then
    function automatic t_val rand_val();
        if ($urandom_range(0, 9) == 0)
            return 3'd7;
        return t_val'($urandom_range(0, 6));
    endfunction

    function automatic logic [4:0] rand_ix();
        return 5'($urandom_range(0, 31));
    endfunction

    // drive one command word and hold it until the block takes it
    task automatic issue(input logic [2:0] act, input t_val a, input t_val b,
                         input t_val mv, input logic [4:0] ix);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_action      <= act;
        i_pip_a       <= a;
        i_pip_b       <= b;
        i_match_value <= mv;
        i_entry_index <= ix;
        start         <= 1'b1;
        do @(posedge i_clk); while (busy);
        sent++;
    endtask

    // hold off until every predicted word has come back
    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (words_pending != 0);
    endtask

    // random command of any kind, any field values
    task automatic random_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            issue(ACT_INSERT, rand_val(), rand_val(), rand_val(), rand_ix());
        else if (r < 30)
            issue(ACT_FIND, rand_val(), rand_val(), rand_val(), rand_ix());
        else if (r < 45)
            issue(ACT_REMOVE, rand_val(), rand_val(), rand_val(), rand_ix());
        else if (r < 65)
            issue(ACT_SELECT, rand_val(), rand_val(), 3'($urandom_range(0, 7)), rand_ix());
        else if (r < 85)
            issue(ACT_READ, rand_val(), rand_val(), rand_val(), rand_ix());
        else if (r < 92)
            issue(ACT_SORT, rand_val(), rand_val(), rand_val(), rand_ix());
        else
            issue(3'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI)), rand_val(), rand_val(),
                  rand_val(), rand_ix());
    endtask

    initial begin : stimulus
        int   n;
        int   k;
        int   m;
        int   r;
        bit   first_round;
        t_val pa;
        t_val pb;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        // empty table: every lookup misses
        issue(ACT_READ,   3'd0, 3'd0, 3'd0, 5'd0);
        issue(ACT_FIND,   3'd0, 3'd0, 3'd0, 5'd0);
        issue(ACT_REMOVE, 3'd1, 3'd2, 3'd0, 5'd0);
        issue(ACT_SELECT, 3'd0, 3'd0, 3'd0, 5'd0);
        issue(ACT_SORT,   3'd0, 3'd0, 3'd0, 5'd0);
        // fill with extremes, seven included, and a reversed duplicate
        issue(ACT_INSERT, 3'd6, 3'd6, 3'd0, 5'd0);
        issue(ACT_INSERT, 3'd0, 3'd0, 3'd7, 5'd31);
        issue(ACT_INSERT, 3'd7, 3'd7, 3'd0, 5'd0);
        issue(ACT_INSERT, 3'd3, 3'd5, 3'd0, 5'd0);
        issue(ACT_INSERT, 3'd5, 3'd3, 3'd0, 5'd0);
        issue(ACT_INSERT, 3'd0, 3'd7, 3'd0, 5'd0);
        issue(ACT_FIND,   3'd5, 3'd3, 3'd0, 5'd0);
        issue(ACT_FIND,   3'd7, 3'd0, 3'd0, 5'd0);
        issue(ACT_SELECT, 3'd0, 3'd0, 3'd7, 5'd0);
        issue(ACT_SELECT, 3'd0, 3'd0, 3'd0, 5'd0);
        issue(ACT_READ,   3'd0, 3'd0, 3'd0, 5'd31);
        issue(ACT_READ,   3'd0, 3'd0, 3'd0, 5'd4);
        issue(ACT_UNDEF_LO, 3'd0, 3'd0, 3'd0, 5'd0);
        issue(ACT_UNDEF_HI, 3'd7, 3'd7, 3'd7, 5'd31);
        issue(ACT_SORT,   3'd0, 3'd0, 3'd0, 5'd0);
        issue(ACT_READ,   3'd0, 3'd0, 3'd0, 5'd0);
        issue(ACT_REMOVE, 3'd6, 3'd6, 3'd0, 5'd0);
        issue(ACT_REMOVE, 3'd6, 3'd6, 3'd0, 5'd0);
        issue(ACT_SELECT, 3'd0, 3'd0, 3'd4, 5'd0);
        wait_idle();

        // rounds: fill from a shuffled deck, probe, sort, then drain
        first_round = 1'b1;
        while (sent < ITEMS) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            n = 0;
            for (int a = 0; a < 7; a++) begin
                for (int b = a; b < 7; b++) begin
                    deck_a[n] = t_val'(a);
                    deck_b[n] = t_val'(b);
                    n++;
                end
            end
            for (int j = MAX_ENTRIES - 1; j > 0; j--) begin
                r = $urandom_range(0, j);
                pa = deck_a[j]; deck_a[j] = deck_a[r]; deck_a[r] = pa;
                pb = deck_b[j]; deck_b[j] = deck_b[r]; deck_b[r] = pb;
            end
            k = ($urandom_range(0, 2) == 0) ? $urandom_range(4, MAX_ENTRIES - 1) : MAX_ENTRIES;

            // fill phase with random orientation and noise in between
            for (int j = 0; j < k; j++) begin
                if ($urandom_range(0, 1) == 1)
                    issue(ACT_INSERT, deck_a[j], deck_b[j], rand_val(), rand_ix());
                else
                    issue(ACT_INSERT, deck_b[j], deck_a[j], rand_val(), rand_ix());
                if ($urandom_range(0, 3) == 0)
                    random_op();
            end
            // table near or at full: duplicates and full rejects
            repeat ($urandom_range(2, 5))
                issue(ACT_INSERT, rand_val(), rand_val(), rand_val(), rand_ix());
            repeat (3)
                issue(ACT_SELECT, rand_val(), rand_val(), 3'($urandom_range(0, 7)), rand_ix());
            issue(ACT_SORT, rand_val(), rand_val(), rand_val(), rand_ix());
            repeat (4)
                issue(ACT_READ, rand_val(), rand_val(), rand_val(), rand_ix());
            repeat (2)
                issue(ACT_SELECT, rand_val(), rand_val(), 3'($urandom_range(0, 7)), rand_ix());

            // drain phase removes deck pairs in random orientation
            m = $urandom_range(k / 2, k);
            for (int j = 0; j < m; j++) begin
                if ($urandom_range(0, 1) == 1) begin
                    pa = deck_a[k - 1 - j];
                    pb = deck_b[k - 1 - j];
                end else begin
                    pa = deck_b[k - 1 - j];
                    pb = deck_a[k - 1 - j];
                end
                issue(ACT_REMOVE, pa, pb, rand_val(), rand_ix());
                if ($urandom_range(0, 3) == 0)
                    random_op();
            end

            if (first_round || $urandom_range(0, 1) == 1)
                wait_idle();
            first_round = 1'b0;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && words_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
